@@ src/rlp_stream_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// RLP decoder assertion macros
// Shared property shorthands for the decoder checks.
// ----------------------------------------------------------------------------
`ifndef RLP_STREAM_DECODER_MACROS_SVH
`define RLP_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RLP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/rlp_pkg.sv @@
// ----------------------------------------------------------------------------
// RLP decoder package
// Widths, token and error codes, and the stack control type.
// ----------------------------------------------------------------------------
package rlp_pkg;

    // Deepest list nesting that the stack holds.
    localparam int MAX_DEPTH = 16;
    localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
    localparam int POS_W     = 26;
    localparam int LEN_W     = 24;
    localparam int DEPTH_W   = 5;

    // Prefix byte boundaries.
    localparam logic [7:0] C_SHORT_STR  = 8'h80;
    localparam logic [7:0] C_LONG_STR   = 8'hB8;
    localparam logic [7:0] C_SHORT_LIST = 8'hC0;
    localparam logic [7:0] C_LONG_LIST  = 8'hF8;
    localparam logic [7:0] C_STR_BASE   = 8'hB7;
    localparam logic [7:0] C_LIST_BASE  = 8'hF7;
    localparam logic [LEN_W-1:0] C_ACC_LIMIT = 24'd65535;

    typedef enum logic [2:0] {
        K_HDR   = 3'd0,
        K_DATA  = 3'd1,
        K_OPEN  = 3'd2,
        K_CLOSE = 3'd3,
        K_DONE  = 3'd4,
        K_ERR   = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE     = 3'd0,
        E_TRUNC    = 3'd1,
        E_TOO_BIG  = 3'd2,
        E_OVERRUN  = 3'd3,
        E_TOO_DEEP = 3'd4,
        E_EMPTY    = 3'd5
    } t_err;

    // Push or pop request to the row of stack cells.
    typedef struct packed {
        logic             push;
        logic             pop;
        logic [POS_W-1:0] din;
    } t_stk_ctl;

endpackage

@@ src/rlp_in_if.sv @@
// ----------------------------------------------------------------------------
// RLP input channel
// Valid/ready channel carrying one encoded byte per item.
// ----------------------------------------------------------------------------
interface rlp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink (input valid, data_byte, last_byte, output ready);
endinterface

@@ src/rlp_out_if.sv @@
// ----------------------------------------------------------------------------
// RLP output channel
// Valid/ready channel carrying one decoded token per item.
// ----------------------------------------------------------------------------
interface rlp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [23:0] value;
    logic [4:0]  depth;
    logic [2:0]  error_code;
    logic        last_result;

    modport source (output valid, kind, value, depth, error_code, last_result,
                    input ready);
    modport sink (input valid, kind, value, depth, error_code, last_result,
                  output ready);
endinterface

@@ src/rlp_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// RLP stream decoder
// Parses one top-level RLP item from a byte stream into a token stream.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  i_in     | in        | data_byte, last_byte
//  o_out    | out       | kind, value, depth, error_code, last_result
//
// One byte is taken in S_IN, then evaluated in S_EVAL and as needed S_DATA1,
// S_LCHK, S_BEGIN and S_CLOSE, one S_CLOSE pass per list that closes on it,
// then S_LAST and S_FLUSH; the sequencer emits at most one token per cycle and
// is held by a stalled output. List closes walk the stack cell row, one pop per
// cycle through cell zero while not stalled. Each token is held in a pending
// register so the final token of a byte can be flagged; reset is synchronous, active low.
// ----------------------------------------------------------------------------
module rlp_stream_decoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rlp_in_if.sink          i_in,
    rlp_out_if.source       o_out
);
    import rlp_pkg::*;
    `include "rlp_stream_decoder_macros.svh"

    typedef enum logic [3:0] {
        S_IN, S_EVAL, S_DATA1, S_LCHK, S_BEGIN, S_CLOSE, S_LAST, S_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_LEN    = 2'd1,
        PH_DATA   = 2'd2,
        PH_IDLE   = 2'd3
    } t_phase;

    typedef struct packed {
        t_kind              kind;
        logic [LEN_W-1:0]   value;
        logic [DEPTH_W-1:0] depth;
        t_err               err;
    } t_tok;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [7:0]       r_b, n_b;
    logic             r_last, n_last;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [LVL_W-1:0] r_level, n_level;
    logic [3:0]       r_lbl, n_lbl;
    logic [LEN_W-1:0] r_accum, n_accum;
    logic [LEN_W-1:0] r_strl, n_strl;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_is_list, n_is_list;
    logic             r_fin, n_fin;
    logic             r_err, n_err;
    t_tok             r_pend, n_pend;
    logic             r_pv, n_pv;
    t_tok             r_otok, n_otok;
    logic             r_olast, n_olast;
    logic             r_ov, n_ov;

    t_stk_ctl         w_stk;
    logic [POS_W-1:0] w_top;
    logic             w_go;
    logic             w_emit;
    t_tok             w_tok;
    logic [7:0]       w_plen;
    logic             w_long;
    logic [LEN_W-1:0] w_cmp_len;
    logic             w_over;
    logic [LEN_W-1:0] w_new_acc;
    logic [3:0]       w_lbl_dec;

    rlp_stack u_stack (
        .i_clk (i_clk),
        .i_ctl (w_stk),
        .o_top (w_top)
    );

    // Prefix decode and the one overrun comparator.
    always_comb begin
        w_long = (r_b >= C_LONG_STR && r_b < C_SHORT_LIST) || (r_b >= C_LONG_LIST);
        if (r_b < C_LONG_STR) begin
            w_plen = r_b - C_SHORT_STR;
        end else if (r_b < C_SHORT_LIST) begin
            w_plen = r_b - C_STR_BASE;
        end else if (r_b < C_LONG_LIST) begin
            w_plen = r_b - C_SHORT_LIST;
        end else begin
            w_plen = r_b - C_LIST_BASE;
        end
        w_cmp_len = (r_state == S_LCHK) ? r_len : LEN_W'(w_plen);
        w_over = (r_level != '0) &&
                 (({1'b0, r_pos} + (POS_W+1)'(w_cmp_len)) > {1'b0, w_top});
        w_new_acc = {r_accum[LEN_W-9:0], r_b};
        w_lbl_dec = (r_lbl != 4'd0) ? r_lbl - 4'd1 : 4'd0;
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;   n_phase = r_phase;   n_b = r_b;     n_last = r_last;
        n_pos = r_pos;       n_level = r_level;   n_lbl = r_lbl; n_accum = r_accum;
        n_strl = r_strl;     n_len = r_len;       n_is_list = r_is_list;
        n_fin = r_fin;       n_err = r_err;       n_pend = r_pend; n_pv = r_pv;
        n_otok = r_otok;     n_olast = r_olast;
        w_emit = 1'b0;
        w_tok = '{kind: K_HDR, value: '0, depth: DEPTH_W'(r_level), err: E_NONE};
        w_stk = '{push: 1'b0, pop: 1'b0, din: r_pos + POS_W'(r_len)};
        w_go = !r_ov || o_out.ready;
        n_ov = (r_ov && !o_out.ready);

        case (r_state)
            S_IN: begin
                if (i_in.valid) begin
                    n_b = i_in.data_byte;
                    n_last = i_in.last_byte;
                    if (r_phase != PH_IDLE) begin
                        n_pos = r_pos + POS_W'(1);
                    end
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (w_go) begin
                    case (r_phase)
                        PH_PREFIX: begin
                            if (r_b < C_SHORT_STR) begin
                                w_emit = 1'b1;
                                w_tok.value = LEN_W'(1);
                                n_state = S_DATA1;
                            end else if (w_over) begin
                                w_emit = 1'b1;
                                w_tok.kind = K_ERR;
                                w_tok.err = E_OVERRUN;
                                n_err = 1'b1;
                                n_phase = PH_IDLE;
                                n_state = S_LAST;
                            end else if (w_long) begin
                                n_is_list = (r_b >= C_LONG_LIST);
                                n_lbl = w_plen[3:0];
                                n_accum = '0;
                                n_phase = PH_LEN;
                                n_state = S_LAST;
                            end else begin
                                n_len = LEN_W'(w_plen);
                                n_is_list = (r_b >= C_SHORT_LIST);
                                n_state = S_BEGIN;
                            end
                        end
                        PH_LEN: begin
                            if (r_accum > C_ACC_LIMIT) begin
                                w_emit = 1'b1;
                                w_tok.kind = K_ERR;
                                w_tok.err = E_TOO_BIG;
                                n_err = 1'b1;
                                n_phase = PH_IDLE;
                                n_state = S_LAST;
                            end else begin
                                n_accum = w_new_acc;
                                n_lbl = w_lbl_dec;
                                if (w_lbl_dec == 4'd0) begin
                                    n_len = w_new_acc;
                                    n_state = S_LCHK;
                                end else begin
                                    n_state = S_LAST;
                                end
                            end
                        end
                        PH_DATA: begin
                            w_emit = 1'b1;
                            w_tok.kind = K_DATA;
                            w_tok.value = LEN_W'(r_b);
                            n_strl = (r_strl != '0) ? r_strl - LEN_W'(1) : '0;
                            n_state = (n_strl == '0) ? S_CLOSE : S_LAST;
                        end
                        default: begin
                            n_state = S_LAST;
                        end
                    endcase
                end
            end
            S_DATA1: begin
                if (w_go) begin
                    w_emit = 1'b1;
                    w_tok.kind = K_DATA;
                    w_tok.value = LEN_W'(r_b);
                    n_state = S_CLOSE;
                end
            end
            S_LCHK: begin
                if (w_go) begin
                    if (w_over) begin
                        w_emit = 1'b1;
                        w_tok.kind = K_ERR;
                        w_tok.err = E_OVERRUN;
                        n_err = 1'b1;
                        n_phase = PH_IDLE;
                        n_state = S_LAST;
                    end else begin
                        n_state = S_BEGIN;
                    end
                end
            end
            S_BEGIN: begin
                if (w_go) begin
                    w_emit = 1'b1;
                    if (r_is_list && r_level >= LVL_W'(MAX_DEPTH)) begin
                        w_tok.kind = K_ERR;
                        w_tok.err = E_TOO_DEEP;
                        n_err = 1'b1;
                        n_phase = PH_IDLE;
                        n_state = S_LAST;
                    end else if (r_is_list) begin
                        w_tok.kind = K_OPEN;
                        w_tok.value = r_len;
                        w_stk.push = 1'b1;
                        n_level = r_level + LVL_W'(1);
                        n_phase = PH_PREFIX;
                        n_state = (r_len == '0) ? S_CLOSE : S_LAST;
                    end else begin
                        w_tok.value = r_len;
                        n_strl = r_len;
                        n_phase = PH_DATA;
                        n_state = (r_len == '0) ? S_CLOSE : S_LAST;
                    end
                end
            end
            S_CLOSE: begin
                if (w_go) begin
                    if (r_level != '0 && w_top == r_pos) begin
                        w_emit = 1'b1;
                        w_tok.kind = K_CLOSE;
                        w_tok.depth = DEPTH_W'(r_level - LVL_W'(1));
                        w_stk.pop = 1'b1;
                        n_level = r_level - LVL_W'(1);
                    end else if (r_level == '0) begin
                        w_emit = 1'b1;
                        w_tok.kind = K_DONE;
                        w_tok.depth = '0;
                        n_fin = 1'b1;
                        n_phase = PH_IDLE;
                        n_state = S_LAST;
                    end else begin
                        n_phase = PH_PREFIX;
                        n_state = S_LAST;
                    end
                end
            end
            S_LAST: begin
                if (w_go) begin
                    if (r_last) begin
                        if (!r_fin && !r_err) begin
                            w_emit = 1'b1;
                            w_tok.kind = K_ERR;
                            w_tok.err = E_TRUNC;
                        end
                        // A final byte starts the next buffer afresh.
                        n_level = '0;    n_phase = PH_PREFIX; n_lbl = '0;
                        n_accum = '0;    n_strl = '0;         n_pos = '0;
                        n_is_list = 1'b0; n_fin = 1'b0;       n_err = 1'b0;
                    end
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (w_go) begin
                    if (r_pv) begin
                        n_otok = r_pend;
                        n_olast = 1'b1;
                        n_ov = 1'b1;
                        n_pv = 1'b0;
                    end
                    n_state = S_IN;
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase

        // A new token pushes the held one out, not yet marked as last.
        if (w_emit) begin
            if (r_pv) begin
                n_otok = r_pend;
                n_olast = 1'b0;
                n_ov = 1'b1;
            end
            n_pend = w_tok;
            n_pv = 1'b1;
        end
    end

    // State and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;   r_phase <= PH_PREFIX; r_pos <= '0;   r_level <= '0;
            r_lbl <= '0;       r_accum <= '0;        r_strl <= '0;  r_is_list <= 1'b0;
            r_fin <= 1'b0;     r_err <= 1'b0;        r_pv <= 1'b0;  r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_phase <= n_phase;  r_pos <= n_pos; r_level <= n_level;
            r_lbl <= n_lbl;     r_accum <= n_accum;  r_strl <= n_strl;
            r_is_list <= n_is_list;
            r_fin <= n_fin;     r_err <= n_err;      r_pv <= n_pv;  r_ov <= n_ov;
        end
        r_b <= n_b;
        r_last <= n_last;
        r_len <= n_len;
        r_pend <= n_pend;
        r_otok <= n_otok;
        r_olast <= n_olast;
    end

    assign i_in.ready        = (r_state == S_IN);
    assign o_out.valid       = r_ov;
    assign o_out.kind        = r_otok.kind;
    assign o_out.value       = r_otok.value;
    assign o_out.depth       = r_otok.depth;
    assign o_out.error_code  = r_otok.err;
    assign o_out.last_result = r_olast;

    // Checks on the stack bookkeeping and the token stream.
    `RLP_ASSERT_NOW(a_push_room, w_stk.push, r_level < LVL_W'(MAX_DEPTH), "push at full depth")
    `RLP_ASSERT_NOW(a_pop_level, w_stk.pop, r_level != '0, "pop of an empty stack")
    `RLP_ASSERT_NOW(a_err_code, o_out.valid, (o_out.kind == K_ERR) == (o_out.error_code != E_NONE), "error code mismatch")
    `RLP_ASSERT_NEXT(a_no_stale, i_in.valid && i_in.ready, !r_pv, "token held across items")
endmodule

@@ src/rlp_cell.sv @@
// ----------------------------------------------------------------------------
// RLP stack cell
// One entry of the list end stack; shifts with its neighbors on push and pop.
// ----------------------------------------------------------------------------
module rlp_cell (
    input  logic                  i_clk,
    input  rlp_pkg::t_stk_ctl     i_ctl,
    input  logic [rlp_pkg::POS_W-1:0] i_from_up,
    input  logic [rlp_pkg::POS_W-1:0] i_from_down,
    output logic [rlp_pkg::POS_W-1:0] o_entry
);
    import rlp_pkg::*;

    logic [POS_W-1:0] r_entry;

    // A push takes the entry above, a pop takes the entry below.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_entry <= i_from_up;
        end else if (i_ctl.pop) begin
            r_entry <= i_from_down;
        end
    end

    assign o_entry = r_entry;
endmodule

@@ src/rlp_stack.sv @@
// ----------------------------------------------------------------------------
// RLP list end stack
// A row of cells; cell zero is the top of stack.
// ----------------------------------------------------------------------------
module rlp_stack (
    input  logic                      i_clk,
    input  rlp_pkg::t_stk_ctl         i_ctl,
    output logic [rlp_pkg::POS_W-1:0] o_top
);
    import rlp_pkg::*;

    logic [POS_W-1:0] w_entry [MAX_DEPTH];
    logic [POS_W-1:0] w_up    [MAX_DEPTH];
    logic [POS_W-1:0] w_down  [MAX_DEPTH];

    // Wire each cell to its neighbors; the ends take the new value or zero.
    for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_up[g] = i_ctl.din;
        end else begin : g_body
            assign w_up[g] = w_entry[g-1];
        end
        if (g == MAX_DEPTH - 1) begin : g_tail
            assign w_down[g] = '0;
        end else begin : g_mid
            assign w_down[g] = w_entry[g+1];
        end
        rlp_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_from_up   (w_up[g]),
            .i_from_down (w_down[g]),
            .o_entry     (w_entry[g])
        );
    end

    assign o_top = w_entry[0];
endmodule
